// ===== rtl/mwqm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwqm_pkg
// Shared widths, codes and divider handshake types for the quota meter.
// ----------------------------------------------------------------------------
package mwqm_pkg;

	localparam int unsigned DATA_W    = 48;
	localparam int unsigned DUR_W     = 32;
	localparam int unsigned NREG_WIN  = 4;
	localparam int unsigned WIN_IDX_W = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned RES_W     = 3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXCEEDED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LIMIT_WR = 2'd2;

	localparam logic ACT_CONSUME = 1'b0;
	localparam logic ACT_LIMIT   = 1'b1;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DUR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DUR_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/mwqm_div.sv =====
// ----------------------------------------------------------------------------
// mwqm_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mwqm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mwqm_pkg::div_req_t req,
	output mwqm_pkg::div_rsp_t rsp
);

	localparam int unsigned CW = $clog2(mwqm_pkg::DATA_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [mwqm_pkg::DATA_W-1:0] num_q;
	logic [mwqm_pkg::DUR_W-1:0]  den_q;
	logic [mwqm_pkg::DUR_W-1:0]  rem_q;
	logic [mwqm_pkg::DUR_W:0]    trial;
	logic [mwqm_pkg::DUR_W:0]    diff;
	logic                        ge;

	always_comb begin
		trial = {rem_q, num_q[mwqm_pkg::DATA_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(mwqm_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[mwqm_pkg::DUR_W-1:0] : trial[mwqm_pkg::DUR_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/multi_window_quota_meter_unit.sv =====
// ----------------------------------------------------------------------------
// multi_window_quota_meter_unit
// Fixed-window quota meter: limits and usage per window and resource.
// ----------------------------------------------------------------------------
// One word at a time: start is taken while busy is low and the result shows
// for one cycle with done; it cannot be held off. A limit write, a zero
// amount or an unknown resource goes straight to the result. A consume checks
// each window for rollover, reads and compares the limit and usage memories
// for each window, grants, writes usage back to each window if any window is
// enabled, and then gives the result. Each window that rolls over adds one or
// two passes of the 48-step remainder unit, one for the offset and one for the
// phase of now. Limits and usage sit in two synchronous memories, the usage
// memory single-port and the limit memory with a separate write address;
// per-entry valid flops stand for reset.
module multi_window_quota_meter_unit #(
	parameter int RESOURCE_TYPES = 8,
	parameter int WINDOWS        = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mwqm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwqm_pkg::DUR_W-1:0]     cfg_wdata,
	input  logic                           start,
	output logic                           busy,
	input  logic                           action,
	input  logic [mwqm_pkg::RES_W-1:0]     resource,
	input  logic [mwqm_pkg::DATA_W-1:0]    amount,
	input  logic [mwqm_pkg::WIN_IDX_W-1:0] window_select,
	input  logic [mwqm_pkg::DATA_W-1:0]    now,
	output logic                           done,
	output logic [mwqm_pkg::STATUS_W-1:0]  status,
	output logic [mwqm_pkg::WIN_IDX_W-1:0] limiting_window,
	output logic [mwqm_pkg::DUR_W-1:0]     window_length,
	output logic [mwqm_pkg::DATA_W-1:0]    window_end,
	output logic [mwqm_pkg::DATA_W-1:0]    window_limit,
	output logic [mwqm_pkg::DATA_W-1:0]    left_over
);

	localparam int DEPTH = WINDOWS * RESOURCE_TYPES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = mwqm_pkg::DATA_W;
	localparam int NW    = mwqm_pkg::NREG_WIN;
	localparam int WW    = mwqm_pkg::WIN_IDX_W;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ROLL    = 4'd1;
	localparam logic [3:0] S_DIV_OFF = 4'd2;
	localparam logic [3:0] S_DIV_PH  = 4'd3;
	localparam logic [3:0] S_RD      = 4'd4;
	localparam logic [3:0] S_CMP     = 4'd5;
	localparam logic [3:0] S_GRANT   = 4'd6;
	localparam logic [3:0] S_UPD     = 4'd7;
	localparam logic [3:0] S_RESP    = 4'd8;

	logic [3:0]                 state_q;
	logic [WW-1:0]              w_q;
	logic [mwqm_pkg::DUR_W-1:0] dur_q [NW];
	logic [mwqm_pkg::DUR_W-1:0] off_q [NW];
	logic [DW-1:0]              end_q [NW];
	logic [DW-1:0]              use_q [NW];
	logic [DEPTH-1:0]           lim_vld_q;
	logic [DEPTH-1:0]           use_vld_q;
	logic [DW-1:0]              lim_mem_q [DEPTH];
	logic [DW-1:0]              use_mem_q [DEPTH];
	logic [DW-1:0]              lim_rd_s1;
	logic [DW-1:0]              use_rd_s1;
	logic                       lim_vld_s1;
	logic                       use_vld_s1;
	logic [mwqm_pkg::RES_W-1:0] res_q;
	logic [DW-1:0]              amt_q;
	logic [DW-1:0]              now_q;
	logic                       found_q;
	logic [WW-1:0]              best_q;
	logic [DW-1:0]              min_q;
	logic [DW-1:0]              lim_best_q;
	logic [DW-1:0]              grant_q;

	logic [mwqm_pkg::STATUS_W-1:0] status_q;
	logic [WW-1:0]                 lwin_q;
	logic [mwqm_pkg::DUR_W-1:0]    wlen_q;
	logic [DW-1:0]                 wend_q;
	logic [DW-1:0]                 wlim_q;
	logic [DW-1:0]                 left_q;

	mwqm_pkg::div_req_t div_req;
	mwqm_pkg::div_rsp_t div_rsp;

	logic          accept;
	logic          res_ok;
	logic          wsel_ok;
	logic          lim_we;
	logic [AW-1:0] lim_wa;
	logic [AW-1:0] cur_addr;
	logic          en_cur;
	logic          expired;
	logic          last_w;
	logic          ph_start;
	logic          clr_row;
	logic [DW:0]   end_sum;
	logic [DW-1:0] new_end;
	logic [DW-1:0] lim_cur;
	logic [DW-1:0] use_cur;
	logic [DW-1:0] free_cur;
	logic [DW:0]   use_sum;
	logic [DW-1:0] use_wd;
	logic          use_we;

	mwqm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		accept   = start && (state_q == S_IDLE);
		res_ok   = int'(resource) < RESOURCE_TYPES;
		wsel_ok  = int'(window_select) < WINDOWS;
		lim_we   = accept && (action == mwqm_pkg::ACT_LIMIT) && res_ok && wsel_ok;
		lim_wa   = AW'(int'(window_select) * RESOURCE_TYPES + int'(resource));
		cur_addr = AW'(int'(w_q) * RESOURCE_TYPES + int'(res_q));
		en_cur   = dur_q[w_q] != '0;
		expired  = now_q >= end_q[w_q];
		last_w   = w_q == WW'(WINDOWS - 1);
		ph_start = (state_q == S_DIV_OFF) && div_rsp.done && !(now_q < DW'(div_rsp.rem));
		clr_row  = ((state_q == S_DIV_OFF) && div_rsp.done && !ph_start)
			|| ((state_q == S_DIV_PH) && div_rsp.done);
		end_sum  = {1'b0, now_q} - {{(DW + 1 - mwqm_pkg::DUR_W){1'b0}}, div_rsp.rem}
			+ {{(DW + 1 - mwqm_pkg::DUR_W){1'b0}}, dur_q[w_q]};
		new_end  = end_sum[DW] ? {DW{1'b1}} : end_sum[DW-1:0];
		lim_cur  = lim_vld_s1 ? lim_rd_s1 : {DW{1'b1}};
		use_cur  = use_vld_s1 ? use_rd_s1 : '0;
		free_cur = (lim_cur > use_cur) ? lim_cur - use_cur : '0;
		use_sum  = {1'b0, use_q[w_q]} + {1'b0, grant_q};
		use_wd   = use_sum[DW] ? {DW{1'b1}} : use_sum[DW-1:0];
		use_we   = (state_q == S_UPD) && en_cur;

		div_req.start    = ((state_q == S_ROLL) && en_cur && expired) || ph_start;
		div_req.dividend = (state_q == S_ROLL) ? DW'(off_q[w_q])
			: now_q - DW'(div_rsp.rem);
		div_req.divisor  = dur_q[w_q];
	end

	always_ff @(posedge clk) begin
		if (lim_we)
			lim_mem_q[lim_wa] <= amount;
		lim_rd_s1 <= lim_mem_q[cur_addr];
	end

	always_ff @(posedge clk) begin
		if (use_we)
			use_mem_q[cur_addr] <= use_wd;
		use_rd_s1 <= use_mem_q[cur_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) begin
				dur_q[i] <= '0;
				off_q[i] <= '0;
				end_q[i] <= '0;
			end
			lim_vld_q <= '0;
			use_vld_q <= '0;
			state_q   <= S_IDLE;
			w_q       <= '0;
			found_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (int'(cfg_index) < NW)
					dur_q[WW'(cfg_index)] <= cfg_wdata;
				else
					off_q[WW'(int'(cfg_index) - NW)] <= cfg_wdata;
			end
			if (lim_we)
				lim_vld_q[lim_wa] <= 1'b1;
			if (use_we)
				use_vld_q[cur_addr] <= 1'b1;
			if (clr_row) begin
				end_q[w_q] <= (state_q == S_DIV_OFF) ? DW'(div_rsp.rem) : new_end;
				for (int i = 0; i < DEPTH; i++) begin
					if (i / RESOURCE_TYPES == int'(w_q))
						use_vld_q[i] <= 1'b0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						w_q     <= '0;
						found_q <= 1'b0;
						if (action == mwqm_pkg::ACT_LIMIT || amount == '0 || !res_ok)
							state_q <= S_RESP;
						else
							state_q <= S_ROLL;
					end
				end
				S_ROLL: begin
					if (en_cur && expired) begin
						state_q <= S_DIV_OFF;
					end else if (last_w) begin
						w_q     <= '0;
						state_q <= S_RD;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_DIV_OFF, S_DIV_PH: begin
					if (ph_start) begin
						state_q <= S_DIV_PH;
					end else if (clr_row) begin
						if (last_w) begin
							w_q     <= '0;
							state_q <= S_RD;
						end else begin
							w_q     <= w_q + 1'b1;
							state_q <= S_ROLL;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (en_cur && (!found_q || free_cur < min_q))
						found_q <= 1'b1;
					if (last_w) begin
						w_q     <= '0;
						state_q <= S_GRANT;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_GRANT: begin
					state_q <= found_q ? S_UPD : S_RESP;
				end
				S_UPD: begin
					if (last_w)
						state_q <= S_RESP;
					else
						w_q <= w_q + 1'b1;
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q    <= resource;
			amt_q    <= amount;
			now_q    <= now;
			status_q <= (action == mwqm_pkg::ACT_LIMIT) ? mwqm_pkg::ST_LIMIT_WR
				: mwqm_pkg::ST_OK;
			lwin_q   <= '0;
			wlen_q   <= '0;
			wend_q   <= '0;
			wlim_q   <= '0;
			left_q   <= '0;
		end
		if (state_q == S_RD) begin
			lim_vld_s1 <= lim_vld_q[cur_addr];
			use_vld_s1 <= use_vld_q[cur_addr];
		end
		if (state_q == S_CMP) begin
			use_q[w_q] <= use_cur;
			if (en_cur && (!found_q || free_cur < min_q)) begin
				min_q      <= free_cur;
				best_q     <= w_q;
				lim_best_q <= lim_cur;
			end
		end
		if (state_q == S_GRANT) begin
			grant_q <= (min_q >= amt_q) ? amt_q : min_q;
			if (found_q && min_q < amt_q) begin
				status_q <= mwqm_pkg::ST_EXCEEDED;
				lwin_q   <= best_q;
				wlen_q   <= dur_q[best_q];
				wend_q   <= end_q[best_q];
				wlim_q   <= lim_best_q;
				left_q   <= amt_q - min_q;
			end
		end
	end

	assign busy            = state_q != S_IDLE;
	assign done            = state_q == S_RESP;
	assign status          = status_q;
	assign limiting_window = lwin_q;
	assign window_length   = wlen_q;
	assign window_end      = wend_q;
	assign window_limit    = wlim_q;
	assign left_over       = left_q;

endmodule

// ===== rtl/mwqm_chk.sv =====
// ----------------------------------------------------------------------------
// mwqm_chk
// Port-level checks on the quota meter's command handshake and results.
// ----------------------------------------------------------------------------
module mwqm_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [mwqm_pkg::STATUS_W-1:0] status,
	input logic [mwqm_pkg::DATA_W-1:0]   left_over
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("word accepted but busy stayed low");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a busy phase");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done) else $error("result not followed by idle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == mwqm_pkg::ST_OK || status == mwqm_pkg::ST_EXCEEDED
			|| status == mwqm_pkg::ST_LIMIT_WR) else $error("bad status code");

	a_left_over: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != mwqm_pkg::ST_EXCEEDED |-> left_over == '0)
		else $error("left over without exceeded status");

endmodule

bind multi_window_quota_meter_unit mwqm_chk u_mwqm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.left_over (left_over)
);

// ===== verif/mwqm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwqm_checker
// Watches the command, configuration and result channels of the quota meter,
// keeps its own copy of windows, limits and usage, predicts each result word
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module mwqm_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mwqm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwqm_pkg::DUR_W-1:0]     cfg_wdata,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           action,
	input  logic [mwqm_pkg::RES_W-1:0]     resource,
	input  logic [mwqm_pkg::DATA_W-1:0]    amount,
	input  logic [mwqm_pkg::WIN_IDX_W-1:0] window_select,
	input  logic [mwqm_pkg::DATA_W-1:0]    now,
	input  logic                           done,
	input  logic [mwqm_pkg::STATUS_W-1:0]  status,
	input  logic [mwqm_pkg::WIN_IDX_W-1:0] limiting_window,
	input  logic [mwqm_pkg::DUR_W-1:0]     window_length,
	input  logic [mwqm_pkg::DATA_W-1:0]    window_end,
	input  logic [mwqm_pkg::DATA_W-1:0]    window_limit,
	input  logic [mwqm_pkg::DATA_W-1:0]    left_over,
	output int                             errors,
	output int                             pending
);

	localparam int NRES = 8;
	localparam int NWIN = 4;
	localparam logic [mwqm_pkg::DATA_W-1:0] ALL_ONES = {mwqm_pkg::DATA_W{1'b1}};

	typedef struct packed {
		logic [mwqm_pkg::STATUS_W-1:0]  status;
		logic [mwqm_pkg::WIN_IDX_W-1:0] win;
		logic [mwqm_pkg::DUR_W-1:0]     len;
		logic [mwqm_pkg::DATA_W-1:0]    wend;
		logic [mwqm_pkg::DATA_W-1:0]    wlim;
		logic [mwqm_pkg::DATA_W-1:0]    rest;
	} verdict_t;

	logic [mwqm_pkg::DUR_W-1:0]  dur [NWIN];
	logic [mwqm_pkg::DUR_W-1:0]  phase [NWIN];
	logic [mwqm_pkg::DATA_W-1:0] ends [NWIN];
	logic [mwqm_pkg::DATA_W-1:0] lim_tab [NWIN*NRES];
	logic [mwqm_pkg::DATA_W-1:0] use_tab [NWIN*NRES];
	verdict_t                    expected_q [$];

	assign pending = expected_q.size();

	function automatic logic [mwqm_pkg::DATA_W-1:0] boundary_after(
			logic [mwqm_pkg::DATA_W-1:0] t,
			logic [mwqm_pkg::DUR_W-1:0] d, logic [mwqm_pkg::DUR_W-1:0] o);
		logic [63:0] ph;
		logic [63:0] e;
		ph = 64'(o) % 64'(d);
		if (64'(t) < ph)
			e = ph;
		else
			e = ((64'(t) - ph) / 64'(d) + 64'd1) * 64'(d) + ph;
		return (e > 64'(ALL_ONES)) ? ALL_ONES : e[mwqm_pkg::DATA_W-1:0];
	endfunction

	function automatic verdict_t meter(logic act, logic [mwqm_pkg::RES_W-1:0] res,
			logic [mwqm_pkg::DATA_W-1:0] amt, logic [mwqm_pkg::WIN_IDX_W-1:0] sel,
			logic [mwqm_pkg::DATA_W-1:0] t);
		verdict_t v;
		logic [mwqm_pkg::DATA_W-1:0] fr, min_free, grant, u;
		int best;
		bit found;
		v = '0;
		found = 0;
		best = 0;
		min_free = '0;
		if (act == mwqm_pkg::ACT_LIMIT) begin
			v.status = mwqm_pkg::ST_LIMIT_WR;
			lim_tab[int'(sel)*NRES + int'(res)] = amt;
			return v;
		end
		v.status = mwqm_pkg::ST_OK;
		if (amt == '0)
			return v;
		for (int w = 0; w < NWIN; w++) begin
			if (dur[w] != '0 && t >= ends[w]) begin
				ends[w] = boundary_after(t, dur[w], phase[w]);
				for (int r = 0; r < NRES; r++)
					use_tab[w*NRES + r] = '0;
			end
		end
		for (int w = 0; w < NWIN; w++) begin
			if (dur[w] != '0) begin
				fr = (lim_tab[w*NRES + res] > use_tab[w*NRES + res]) ?
					lim_tab[w*NRES + res] - use_tab[w*NRES + res] : '0;
				if (!found || fr < min_free) begin
					found = 1;
					min_free = fr;
					best = w;
				end
			end
		end
		if (!found)
			return v;
		grant = (min_free >= amt) ? amt : min_free;
		for (int w = 0; w < NWIN; w++) begin
			if (dur[w] != '0) begin
				u = use_tab[w*NRES + res];
				use_tab[w*NRES + res] = (ALL_ONES - u < grant) ? ALL_ONES : u + grant;
			end
		end
		if (min_free < amt) begin
			v.status = mwqm_pkg::ST_EXCEEDED;
			v.win = mwqm_pkg::WIN_IDX_W'(best);
			v.len = dur[best];
			v.wend = ends[best];
			v.wlim = lim_tab[best*NRES + res];
			v.rest = amt - min_free;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t got, exp_v;
		if (!arst_n) begin
			errors <= 0;
			expected_q.delete();
			for (int w = 0; w < NWIN; w++) begin
				dur[w] = '0;
				phase[w] = '0;
				ends[w] = '0;
			end
			for (int i = 0; i < NWIN*NRES; i++) begin
				lim_tab[i] = ALL_ONES;
				use_tab[i] = '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index < mwqm_pkg::NREG_WIN)
					dur[cfg_index] = cfg_wdata;
				else
					phase[cfg_index - mwqm_pkg::NREG_WIN] = cfg_wdata;
			end
			if (done) begin
				got = '{status, limiting_window, window_length, window_end,
					window_limit, left_over};
				if (expected_q.size() == 0) begin
					$display("%0t: result word with none expected: %p", $time, got);
					errors <= errors + 1;
				end else begin
					exp_v = expected_q.pop_front();
					if (got != exp_v) begin
						$display("%0t: mismatch exp %p", $time, exp_v);
						$display("%0t:          act %p", $time, got);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(meter(action, resource, amount, window_select, now));
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the quota meter through several window settings with directed and
// random commands and random gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

	localparam int REG_DUR0 = 0;
	localparam int REG_OFF0 = 4;
	localparam int IDLE_LIMIT = 4000;
	localparam logic [mwqm_pkg::DATA_W-1:0] ALL_ONES = {mwqm_pkg::DATA_W{1'b1}};

	logic                           clk = 0;
	logic                           arst_n = 0;
	logic                           cfg_we = 0;
	logic [mwqm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mwqm_pkg::DUR_W-1:0]     cfg_wdata = '0;
	logic                           start = 0;
	logic                           busy;
	logic                           action = mwqm_pkg::ACT_CONSUME;
	logic [mwqm_pkg::RES_W-1:0]     resource = '0;
	logic [mwqm_pkg::DATA_W-1:0]    amount = '0;
	logic [mwqm_pkg::WIN_IDX_W-1:0] window_select = '0;
	logic [mwqm_pkg::DATA_W-1:0]    now = '0;
	logic                           done;
	logic [mwqm_pkg::STATUS_W-1:0]  status;
	logic [mwqm_pkg::WIN_IDX_W-1:0] limiting_window;
	logic [mwqm_pkg::DUR_W-1:0]     window_length;
	logic [mwqm_pkg::DATA_W-1:0]    window_end, window_limit, left_over;
	int                             errors, pending;
	int                             n_sent = 0, n_back = 0, idle_cycles = 0;
	logic [mwqm_pkg::DATA_W-1:0]    clock_now = '0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	multi_window_quota_meter_unit dut (.*);
	mwqm_checker chk (.*);

	always @(posedge clk) begin
		if (done)
			n_back++;
		if ((start && !busy) || done)
			idle_cycles = 0;
		else if (++idle_cycles >= IDLE_LIMIT) begin
			$display("** multi_window_quota_meter_unit: FAILED **");
			$finish;
		end
	end

	task automatic send(logic act, logic [mwqm_pkg::RES_W-1:0] res,
			logic [mwqm_pkg::DATA_W-1:0] amt, logic [mwqm_pkg::WIN_IDX_W-1:0] sel,
			logic [mwqm_pkg::DATA_W-1:0] t);
		int gap;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 9) < 3)
			gap = 0;
		if (gap > 0) begin
			@(negedge clk) start <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		action <= act;
		resource <= res;
		amount <= amt;
		window_select <= sel;
		now <= t;
		start <= 1;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	task automatic set_windows(logic [mwqm_pkg::DUR_W-1:0] d [4],
			logic [mwqm_pkg::DUR_W-1:0] o [4]);
		@(negedge clk) start <= 0;
		wait (n_back == n_sent);
		repeat (4) @(negedge clk);
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we <= 1;
			cfg_index <= mwqm_pkg::CFG_IDX_W'(REG_DUR0 + i);
			cfg_wdata <= d[i];
			@(negedge clk);
			cfg_index <= mwqm_pkg::CFG_IDX_W'(REG_OFF0 + i);
			cfg_wdata <= o[i];
		end
		@(negedge clk) cfg_we <= 0;
	endtask

	task automatic random_words(int count);
		logic [mwqm_pkg::DATA_W-1:0] amt;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 25) begin
				case ($urandom_range(0, 5))
					0: amt = ALL_ONES;
					1: amt = mwqm_pkg::DATA_W'({$urandom, $urandom});
					2: amt = '0;
					default: amt = mwqm_pkg::DATA_W'($urandom_range(0, 300));
				endcase
				send(mwqm_pkg::ACT_LIMIT, mwqm_pkg::RES_W'($urandom_range(0, 7)), amt,
					mwqm_pkg::WIN_IDX_W'($urandom_range(0, 3)), '0);
			end else begin
				case ($urandom_range(0, 19))
					0: clock_now = mwqm_pkg::DATA_W'({$urandom, $urandom});
					1: clock_now = ALL_ONES - mwqm_pkg::DATA_W'($urandom_range(0, 40));
					2, 3: clock_now = clock_now
						+ mwqm_pkg::DATA_W'($urandom_range(0, 2000));
					default: clock_now = clock_now
						+ mwqm_pkg::DATA_W'($urandom_range(0, 6));
				endcase
				case ($urandom_range(0, 9))
					0: amt = '0;
					1: amt = mwqm_pkg::DATA_W'({$urandom, $urandom});
					default: amt = mwqm_pkg::DATA_W'($urandom_range(1, 80));
				endcase
				send(mwqm_pkg::ACT_CONSUME, mwqm_pkg::RES_W'($urandom_range(0, 7)), amt,
					mwqm_pkg::WIN_IDX_W'($urandom_range(0, 3)), clock_now);
			end
		end
	endtask

	initial begin
		logic [mwqm_pkg::DUR_W-1:0] d [4];
		logic [mwqm_pkg::DUR_W-1:0] o [4];
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1;

		// unlimited, all windows disabled
		send(mwqm_pkg::ACT_CONSUME, 3'd0, 48'd5, 2'd0, 48'd0);

		d = '{32'd10, 32'd25, 32'd0, 32'd4};
		o = '{32'd3, 32'd30, 32'd7, 32'd1};
		set_windows(d, o);
		send(mwqm_pkg::ACT_LIMIT, 3'd0, 48'd100, 2'd0, '0);
		send(mwqm_pkg::ACT_LIMIT, 3'd0, 48'd50, 2'd1, '0);
		send(mwqm_pkg::ACT_LIMIT, 3'd0, 48'd50, 2'd3, '0);
		send(mwqm_pkg::ACT_LIMIT, 3'd7, 48'd0, 2'd2, '0);
		send(mwqm_pkg::ACT_CONSUME, 3'd0, 48'd0, 2'd0, 48'd2);
		send(mwqm_pkg::ACT_CONSUME, 3'd0, 48'd30, 2'd0, 48'd2);
		send(mwqm_pkg::ACT_CONSUME, 3'd0, 48'd40, 2'd0, 48'd2);
		send(mwqm_pkg::ACT_CONSUME, 3'd0, 48'd1, 2'd0, 48'd5);
		send(mwqm_pkg::ACT_CONSUME, 3'd7, ALL_ONES, 2'd3, 48'd5);
		send(mwqm_pkg::ACT_LIMIT, 3'd5, 48'd0, 2'd1, '0);
		send(mwqm_pkg::ACT_CONSUME, 3'd5, 48'd1, 2'd0, 48'd6);
		send(mwqm_pkg::ACT_CONSUME, 3'd0, ALL_ONES, 2'd0, ALL_ONES);
		send(mwqm_pkg::ACT_CONSUME, 3'd0, 48'd9, 2'd0, ALL_ONES - 48'd1);
		send(mwqm_pkg::ACT_CONSUME, 3'd0, 48'd60, 2'd0, 48'd0);
		random_words(250);

		d = '{32'd0, 32'd0, 32'd0, 32'd0};
		o = '{32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0};
		set_windows(d, o);
		random_words(150);

		d = '{32'd1, 32'hFFFFFFFF, 32'd5, 32'hFFFFFFFF};
		o = '{32'd0, 32'hFFFFFFFF, 32'd2, 32'd123};
		set_windows(d, o);
		clock_now = '0;
		random_words(300);

		for (int i = 0; i < 4; i++) begin
			d[i] = $urandom_range(1, 40);
			o[i] = $urandom_range(0, 50);
		end
		set_windows(d, o);
		random_words(350);

		d = '{32'd16, 32'd16, 32'd16, 32'd16};
		o = '{32'd0, 32'd0, 32'd0, 32'd0};
		set_windows(d, o);
		random_words(300);

		for (int i = 0; i < 4; i++) begin
			d[i] = $urandom;
			o[i] = $urandom;
		end
		set_windows(d, o);
		random_words(300);

		@(negedge clk) start <= 0;
		wait (n_back == n_sent);
		repeat (500) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("** multi_window_quota_meter_unit: PASSED **");
		else
			$display("** multi_window_quota_meter_unit: FAILED **");
		$finish;
	end

endmodule
